[design/gregorian_day_number_converter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the day number converter
// Shared forms for the concurrent checks on the converter ports.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_ASSERT_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_ASSERT_SVH

// same-cycle implication
`define GDNC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GDNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/gdnc_pkg.sv]
// ----------------------------------------------------------------------------
// gdnc_pkg
// Types, constants and calendar tables for the day number converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gdnc_pkg;

   // field widths
   localparam int unsigned YEAR_W   = 14;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned DN_W     = 22;
   localparam int unsigned PACKED_W = 28;
   localparam int unsigned WDAY_W   = 3;
   localparam int unsigned STATUS_W = 3;
   // internal widths: day of year, day accumulator, n*5243 product, dn*11492 product
   localparam int unsigned DOY_W    = 9;
   localparam int unsigned ACC_W    = 23;
   localparam int unsigned P100_W   = 27;
   localparam int unsigned EST_W    = 36;

   // calendar constants
   localparam int unsigned YEAR_MIN      = 1900;
   localparam int unsigned DN_LIMIT      = 4194303;
   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned MONTHS        = 12;
   localparam int unsigned SERIAL_1900   = 365 * 1899 + 1899 / 4 - 1899 / 100 + 1899 / 400 + 1;

   // reciprocals: x/100 = (x*RECIP_100) >> 19 for x < 2^14,
   // (x*RECIP_365) >> 22 is floor(x/365) or one more for x < 2^22
   localparam int unsigned RECIP_100 = 5243;
   localparam int unsigned SHIFT_100 = 19;
   localparam int unsigned RECIP_365 = 11492;
   localparam int unsigned SHIFT_365 = 22;

   // opcodes
   localparam logic OP_TO_SERIAL = 1'b0;
   localparam logic OP_TO_DATE   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_YEAR  = 3'd1,
      STATUS_BAD_MONTH = 3'd2,
      STATUS_BAD_DAY   = 3'd3,
      STATUS_BAD_SPAN  = 3'd4
   } status_type;

   // controller to datapath commands, one per step
   typedef struct packed {
      logic load;
      logic est;
      logic mul;
      logic sum;
      logic eval;
      logic srch;
      logic walk;
      logic fin;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic span_bad;
      logic srch_more;
      logic walk_more;
   } dp_stat_type;

   // days before the first of a month in a common year
   function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] r;
      unique case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // length of a month, zero for a month code outside 1..12
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] r;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
         4'd2:    r = leap ? 5'd29 : 5'd28;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // x mod 7 by folding octal digits (8 is 1 mod 7)
   function automatic logic [WDAY_W-1:0] mod7(input logic [DN_W-1:0] v);
      logic [23:0] ve;
      logic [5:0]  s1;
      logic [3:0]  s2;
      logic [3:0]  s3;
      ve = {2'b00, v};
      s1 = '0;
      for (int i = 0; i < 8; i++) begin
         s1 = s1 + 6'(ve[3*i +: 3]);
      end
      s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
      s3 = 4'(s2[2:0]) + 4'(s2[3]);
      if (s3 >= 4'd7) begin
         s3 = s3 - 4'd7;
      end
      return s3[2:0];
   endfunction

endpackage

`default_nettype wire

[design/gdnc_datapath.sv]
// ----------------------------------------------------------------------------
// gdnc_datapath
// Year base unit, date checks, year search, month walk and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gdnc_datapath #(
   parameter int unsigned YEAR_MAX = 9999
) (
   input  wire logic                              clock,
   input  wire gdnc_pkg::ctrl_cmd_type            cmd,
   input  wire logic [gdnc_pkg::YEAR_W-1:0]       req_year,
   input  wire logic [gdnc_pkg::MONTH_W-1:0]      req_month,
   input  wire logic [gdnc_pkg::DAY_W-1:0]        req_day,
   input  wire logic [gdnc_pkg::DN_W-1:0]         req_serial_day,
   output gdnc_pkg::dp_stat_type                  stat,
   output logic [gdnc_pkg::DN_W-1:0]              rsp_day_number,
   output logic [gdnc_pkg::YEAR_W-1:0]            rsp_out_year,
   output logic [gdnc_pkg::MONTH_W-1:0]           rsp_out_month,
   output logic [gdnc_pkg::DAY_W-1:0]             rsp_out_day,
   output logic [gdnc_pkg::PACKED_W-1:0]          rsp_packed_date,
   output logic [gdnc_pkg::WDAY_W-1:0]            rsp_weekday,
   output logic [gdnc_pkg::STATUS_W-1:0]          rsp_status
);
   import gdnc_pkg::*;

   // last serial day of the span, clipped to the field
   localparam int unsigned HI_FULL = 365 * YEAR_MAX + YEAR_MAX / 4 - YEAR_MAX / 100
                                     + YEAR_MAX / 400;
   localparam int unsigned HI_SPAN = (HI_FULL > DN_LIMIT) ? DN_LIMIT : HI_FULL;
   localparam logic [ACC_W-1:0]  SPAN_HI = ACC_W'(HI_SPAN);
   localparam logic [ACC_W-1:0]  SPAN_LO = ACC_W'(SERIAL_1900);
   localparam logic [YEAR_W-1:0] YMAX    = YEAR_W'(YEAR_MAX);
   localparam logic [YEAR_W-1:0] YMIN    = YEAR_W'(YEAR_MIN);

   // working registers
   logic [YEAR_W-1:0]  y_ff, y_in;
   logic [MONTH_W-1:0] m_ff, m_in;
   logic [DOY_W-1:0]   doy_ff, doy_in;
   logic [ACC_W-1:0]   dn_ff, dn_in;
   status_type         st_ff, st_in;
   logic [YEAR_W-1:0]  n_ff, n_in;
   logic [ACC_W-1:0]   p365_ff, p365_in;
   logic [P100_W-1:0]  p100_ff, p100_in;
   logic [ACC_W-1:0]   base_ff, base_in;
   logic               leap_ff, leap_in;

   // result registers
   logic [DN_W-1:0]     day_number_ff, day_number_in;
   logic [YEAR_W-1:0]   out_year_ff, out_year_in;
   logic [MONTH_W-1:0]  out_month_ff, out_month_in;
   logic [DAY_W-1:0]    out_day_ff, out_day_in;
   logic [PACKED_W-1:0] packed_ff, packed_in;
   logic [WDAY_W-1:0]   weekday_ff, weekday_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // combinational terms
   logic [EST_W-1:0]  est_prod;
   logic [YEAR_W-1:0] est_year;
   logic [YEAR_W-1:0] n_cur;
   logic [7:0]        q100;
   logic [YEAR_W-1:0] q100x;
   logic [YEAR_W-1:0] rem100;
   logic [DAY_W-1:0]  mlen_cur;
   logic [DOY_W-1:0]  before_cur;
   logic [ACC_W-1:0]  dn_calc;
   status_type        eval_st;
   logic              span_bad;
   logic              srch_more;
   logic              walk_more;

   // year estimate, span check, base and leap terms
   always_comb begin
      est_prod = EST_W'(dn_ff[DN_W-1:0]) * EST_W'(RECIP_365);
      est_year = est_prod[EST_W-1 -: YEAR_W] + YEAR_W'(1);
      span_bad = (dn_ff < SPAN_LO) || (dn_ff > SPAN_HI);
      n_cur    = y_ff - YEAR_W'(1);
      q100     = p100_ff[SHIFT_100 +: 8];
      q100x    = YEAR_W'(q100) * YEAR_W'(100);
      rem100   = n_ff - q100x;
   end

   // date checks, serial day for a date, search and walk conditions
   always_comb begin
      mlen_cur   = month_days(m_ff, leap_ff);
      before_cur = month_offset(m_ff) + DOY_W'(leap_ff && (m_ff >= 4'd3));
      dn_calc    = base_ff + ACC_W'(before_cur) + ACC_W'(doy_ff);
      if ((y_ff < YMIN) || (y_ff > YMAX)) begin
         eval_st = STATUS_BAD_YEAR;
      end else if ((m_ff == '0) || (m_ff > MONTH_W'(MONTHS))) begin
         eval_st = STATUS_BAD_MONTH;
      end else if ((doy_ff == '0) || (doy_ff > DOY_W'(mlen_cur))) begin
         eval_st = STATUS_BAD_DAY;
      end else if (dn_calc > ACC_W'(DN_LIMIT)) begin
         eval_st = STATUS_BAD_YEAR;
      end else begin
         eval_st = STATUS_OK;
      end
      srch_more = (y_ff > YMIN) && (base_ff >= dn_ff);
      walk_more = (m_ff < MONTH_W'(MONTHS)) && (doy_ff > DOY_W'(mlen_cur));
   end

   // next values of the working registers
   always_comb begin
      y_in    = y_ff;
      m_in    = m_ff;
      doy_in  = doy_ff;
      dn_in   = dn_ff;
      st_in   = st_ff;
      n_in    = n_ff;
      p365_in = p365_ff;
      p100_in = p100_ff;
      base_in = base_ff;
      leap_in = leap_ff;
      if (cmd.load) begin
         y_in   = req_year;
         m_in   = req_month;
         doy_in = DOY_W'(req_day);
         dn_in  = ACC_W'(req_serial_day);
      end
      if (cmd.est) begin
         y_in  = est_year;
         st_in = span_bad ? STATUS_BAD_SPAN : STATUS_OK;
      end
      if (cmd.mul) begin
         n_in    = n_cur;
         p365_in = ACC_W'(n_cur) * ACC_W'(DAYS_PER_YEAR);
         p100_in = P100_W'(n_cur) * P100_W'(RECIP_100);
      end
      if (cmd.sum) begin
         base_in = p365_ff + ACC_W'(n_ff[YEAR_W-1:2]) + ACC_W'(q100[7:2]) - ACC_W'(q100);
         leap_in = (y_ff[1:0] == 2'b00) && !((rem100 == YEAR_W'(99)) && (q100[1:0] != 2'b11));
      end
      if (cmd.eval) begin
         st_in = eval_st;
         dn_in = dn_calc;
      end
      if (cmd.srch) begin
         if (srch_more) begin
            y_in = y_ff - YEAR_W'(1);
         end else begin
            doy_in = DOY_W'(dn_ff - base_ff);
            m_in   = MONTH_W'(1);
         end
      end
      if (cmd.walk) begin
         doy_in = doy_ff - DOY_W'(mlen_cur);
         m_in   = m_ff + MONTH_W'(1);
      end
   end

   // result assembly, zeros on error
   always_comb begin
      day_number_in = day_number_ff;
      out_year_in   = out_year_ff;
      out_month_in  = out_month_ff;
      out_day_in    = out_day_ff;
      packed_in     = packed_ff;
      weekday_in    = weekday_ff;
      status_in     = status_ff;
      if (cmd.fin) begin
         status_in = st_ff;
         if (st_ff == STATUS_OK) begin
            day_number_in = dn_ff[DN_W-1:0];
            out_year_in   = y_ff;
            out_month_in  = m_ff;
            out_day_in    = doy_ff[DAY_W-1:0];
            packed_in     = PACKED_W'(y_ff) * PACKED_W'(10000)
                            + PACKED_W'(m_ff) * PACKED_W'(100)
                            + PACKED_W'(doy_ff[DAY_W-1:0]);
            weekday_in    = mod7(dn_ff[DN_W-1:0]);
         end else begin
            day_number_in = '0;
            out_year_in   = '0;
            out_month_in  = '0;
            out_day_in    = '0;
            packed_in     = '0;
            weekday_in    = '0;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      y_ff          <= y_in;
      m_ff          <= m_in;
      doy_ff        <= doy_in;
      dn_ff         <= dn_in;
      st_ff         <= st_in;
      n_ff          <= n_in;
      p365_ff       <= p365_in;
      p100_ff       <= p100_in;
      base_ff       <= base_in;
      leap_ff       <= leap_in;
      day_number_ff <= day_number_in;
      out_year_ff   <= out_year_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      packed_ff     <= packed_in;
      weekday_ff    <= weekday_in;
      status_ff     <= status_in;
   end

   assign stat.span_bad  = span_bad;
   assign stat.srch_more = srch_more;
   assign stat.walk_more = walk_more;

   assign rsp_day_number  = day_number_ff;
   assign rsp_out_year    = out_year_ff;
   assign rsp_out_month   = out_month_ff;
   assign rsp_out_day     = out_day_ff;
   assign rsp_packed_date = packed_ff;
   assign rsp_weekday     = weekday_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

[design/gdnc_controller.sv]
// ----------------------------------------------------------------------------
// gdnc_controller
// Sequencer for the conversion steps; issues at most one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdnc_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   req_opcode,
   input  wire gdnc_pkg::dp_stat_type  stat,
   output logic                        busy,
   output logic                        rsp_valid,
   output gdnc_pkg::ctrl_cmd_type      cmd
);
   import gdnc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EST,
      ST_MUL,
      ST_SUM,
      ST_EVAL,
      ST_SRCH,
      ST_WALK,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      op_ff, op_in;
   logic      valid_ff, valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      valid_in = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_opcode;
               state_in = (req_opcode == OP_TO_DATE) ? ST_EST : ST_MUL;
            end
         end
         ST_EST: begin
            cmd.est  = 1'b1;
            state_in = stat.span_bad ? ST_FIN : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = (op_ff == OP_TO_DATE) ? ST_SRCH : ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_FIN;
         end
         ST_SRCH: begin
            cmd.srch = 1'b1;
            state_in = stat.srch_more ? ST_MUL : ST_WALK;
         end
         ST_WALK: begin
            if (stat.walk_more) begin
               cmd.walk = 1'b1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_TO_SERIAL;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

[design/gregorian_day_number_converter.sv]
// Date to serial day: MUL, SUM, EVAL and FIN follow the load. Serial day to date:
// EST, then year probes of the shared year base unit (1, plus about one per 1500
// years of the date), WALK up to the month, FIN. Out-of-span serial day: EST, FIN.
// The result strobe is registered out of FIN. One request at a time; start is
// taken again in the cycle the result strobe is shown. Results cannot be stalled.
// Synchronous active-high reset returns the sequencer to idle and drops the strobe.
// ----------------------------------------------------------------------------
// gregorian_day_number_converter
// Proleptic Gregorian date and serial day number converter, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_day_number_converter #(
   parameter int unsigned YEAR_MAX = 9999
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_opcode,
   input  wire logic [gdnc_pkg::YEAR_W-1:0]       req_year,
   input  wire logic [gdnc_pkg::MONTH_W-1:0]      req_month,
   input  wire logic [gdnc_pkg::DAY_W-1:0]        req_day,
   input  wire logic [gdnc_pkg::DN_W-1:0]         req_serial_day,
   output logic                                   rsp_valid,
   output logic [gdnc_pkg::DN_W-1:0]              rsp_day_number,
   output logic [gdnc_pkg::YEAR_W-1:0]            rsp_out_year,
   output logic [gdnc_pkg::MONTH_W-1:0]           rsp_out_month,
   output logic [gdnc_pkg::DAY_W-1:0]             rsp_out_day,
   output logic [gdnc_pkg::PACKED_W-1:0]          rsp_packed_date,
   output logic [gdnc_pkg::WDAY_W-1:0]            rsp_weekday,
   output logic [gdnc_pkg::STATUS_W-1:0]          rsp_status
);
   import gdnc_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer
   gdnc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   // arithmetic and result registers
   gdnc_datapath #(
      .YEAR_MAX (YEAR_MAX)
   ) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .req_year        (req_year),
      .req_month       (req_month),
      .req_day         (req_day),
      .req_serial_day  (req_serial_day),
      .stat            (stat),
      .rsp_day_number  (rsp_day_number),
      .rsp_out_year    (rsp_out_year),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_day     (rsp_out_day),
      .rsp_packed_date (rsp_packed_date),
      .rsp_weekday     (rsp_weekday),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

[design/gdnc_checker.sv]
// ----------------------------------------------------------------------------
// gdnc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gregorian_day_number_converter_assert.svh"

module gdnc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic [gdnc_pkg::DN_W-1:0]         rsp_day_number,
   input wire logic [gdnc_pkg::MONTH_W-1:0]      rsp_out_month,
   input wire logic [gdnc_pkg::DAY_W-1:0]        rsp_out_day,
   input wire logic [gdnc_pkg::PACKED_W-1:0]     rsp_packed_date,
   input wire logic [gdnc_pkg::WDAY_W-1:0]       rsp_weekday,
   input wire logic [gdnc_pkg::STATUS_W-1:0]     rsp_status
);
   import gdnc_pkg::*;

   // a taken request holds busy in the next cycle
   `GDNC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "request not taken")

   // the result strobe lasts one cycle
   `GDNC_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid, "strobe held")

   // error results carry zero fields
   `GDNC_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK),
      (rsp_day_number == '0) && (rsp_packed_date == '0) && (rsp_weekday == '0) &&
      (rsp_out_month == '0) && (rsp_out_day == '0), "error result not cleared")

   // good results hold a month in 1..12, a nonzero day and a weekday in 0..6
   `GDNC_ASSERT_NOW(a_ok_date, clock, reset, rsp_valid && (rsp_status == STATUS_OK),
      (rsp_out_month != '0) && (rsp_out_month <= 4'd12) && (rsp_out_day != '0) &&
      (rsp_weekday <= 3'd6), "result date out of range")

endmodule

bind gregorian_day_number_converter gdnc_checker u_gdnc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_day_number  (rsp_day_number),
   .rsp_out_month   (rsp_out_month),
   .rsp_out_day     (rsp_out_day),
   .rsp_packed_date (rsp_packed_date),
   .rsp_weekday     (rsp_weekday),
   .rsp_status      (rsp_status)
);

`default_nettype wire
